FILE: hw/rtl/bss_pkg.sv
// Package for the band-limited step synthesiser: widths, command and state codes,
// and the windowed-sinc tap table built at elaboration time.
// Depends on nothing; the step synthesiser top level imports it.
`default_nettype none

package bss_pkg;

  // Synthesis geometry. OVERSAMPLE must be a power of two, since the polyphase
  // split of the fractional position is taken by part-selects.
  localparam int TAPS             = 16;
  localparam int OVERSAMPLE       = 32;
  localparam int SAMPLES_PER_TICK = 48;
  localparam int CUT_NUM          = 5;
  localparam int CUT_DEN          = 11;
  localparam int REF_RATE_KHZ     = 32;
  localparam int OS_W             = $clog2(OVERSAMPLE);
  localparam int ROM_SIZE         = TAPS * OVERSAMPLE;
  localparam int ROM_AW           = $clog2(ROM_SIZE);
  localparam int RING_DEPTH_DEF   = 256;
  localparam int MAX_FRAMES       = 64;

  // Field and datapath widths.
  localparam int POS_W      = 17;
  localparam int POS_FRAC   = 16;
  localparam int LEVEL_W    = 16;
  localparam int FRAME_W    = 7;
  localparam int CMD_W      = 2;
  localparam int SAMPLE_W   = 16;
  localparam int QUIET_W    = 16;
  localparam int TAP_W      = 16;
  localparam int ENTRY_W    = 40;
  localparam int SUM_W      = 48;
  localparam int FADE_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [POS_W-1:0] POS_END = 17'h1_0000;

  // Fixed-point constants of the tap generator.
  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint HALFPI_Q30 = 64'sd1686629713;
  localparam longint TWOPI_Q20  = 64'sd6588397;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP   = 2'd0,
    CMD_RENDER = 2'd1,
    CMD_WAKE   = 2'd2
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_GAIN     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_LEVEL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_DRAIN,
    ST_R_ACC,
    ST_R_MAG,
    ST_R_OUT,
    ST_R_FADE
  } state_e;

  typedef logic [TAP_W-1:0] tap_rom_t [ROM_SIZE];

  // Sine of a Q32 fraction of a turn, Q30 result, by a nested Taylor series.
  function automatic longint sin_turn(input logic [31:0] ph);
    logic [31:0] q;
    logic [63:0] xp;
    longint      x;
    longint      x2;
    longint      t;
    longint      s;
    q = {2'b00, ph[29:0]};
    if (ph[30]) q = 32'h4000_0000 - q;
    xp = {32'd0, q} * HALFPI_Q30;
    x  = longint'(xp >> 30);
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
    s  = (x * t) >>> 30;
    return ph[31] ? -s : s;
  endfunction

  // Restoring long division, used only while the tap table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= dv) begin
        rem    = rem - dv;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One Q1.15 tap: raised-cosine window times sinc, scaled, rounded, saturated.
  function automatic logic [TAP_W-1:0] rom_tap(input int i);
    int          d;
    logic [63:0] ad;
    logic [63:0] wph;
    logic [63:0] sph;
    logic [63:0] ms;
    logic [63:0] m40;
    logic [63:0] g;
    logic [63:0] q;
    logic [63:0] nm;
    longint      win;
    longint      sc;
    longint      num;
    longint      den;
    logic        neg;
    if (i == 0) return '0;
    d   = i - ROM_SIZE / 2;
    ad  = (d < 0) ? 64'(-d) : 64'(d);
    wph = (ad << 32) / 64'(ROM_SIZE);
    win = Q30_ONE + sin_turn(wph[31:0] + 32'h4000_0000);
    if (win < 0) win = 0;
    if (ad == 0) begin
      sc = Q30_ONE;
    end else begin
      sph = ((64'(CUT_NUM) * ad) << 32) / 64'(CUT_DEN * OVERSAMPLE);
      num = sin_turn(sph[31:0]) * longint'(CUT_DEN * OVERSAMPLE) * 64'sd1048576;
      den = TWOPI_Q20 * longint'(CUT_NUM) * longint'(ad);
      nm  = (num < 0) ? 64'(-num) : 64'(num);
      q   = div_u64(nm, 64'(den));
      sc  = (num < 0) ? -longint'(q) : longint'(q);
    end
    neg = (sc < 0);
    ms  = neg ? 64'(-sc) : 64'(sc);
    m40 = (64'(win) * ms) >> 20;
    g   = (m40 * 64'(REF_RATE_KHZ)) / 64'(2 * SAMPLES_PER_TICK);
    q   = (g + 64'h100_0000) >> 25;
    if (neg) return (q > 64'd32768) ? 16'h8000 : TAP_W'(64'd0 - q);
    return (q > 64'd32767) ? 16'h7FFF : TAP_W'(q);
  endfunction

  function automatic tap_rom_t build_rom();
    tap_rom_t rom;
    for (int i = 0; i < ROM_SIZE; i++) rom[i] = rom_tap(i);
    return rom;
  endfunction

  localparam tap_rom_t IMPULSE_ROM = build_rom();

endpackage

`default_nettype wire

FILE: hw/rtl/bss_ring_ram.sv
// Ring of future samples: simple dual-port RAM, one write and one registered read.
// Depends on nothing; instantiated by the step synthesiser top level.
`default_nettype none

module bss_ring_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bandlimited_step_synth.sv
// Band-limited step synthesiser top level: command decode, step and render sequencer.
// Uses bss_pkg and bss_ring_ram. After reset the ring is cleared, one entry a cycle,
// before the first request is taken; configuration is live. A step request works
// one tap a cycle through the ring RAM port; a render request runs the read,
// accumulate, round and fade steps on the ring head for each sample, and waits
// while the sample stream holds back its output.
`default_nettype none

module bandlimited_step_synth #(
  parameter int RING_DEPTH = bss_pkg::RING_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [bss_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bss_pkg::CFG_W-1:0]        cfg_wdata_i,
  // Request stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata, from bit 0: tick_position[16:0], step_level[32:17], frame_count[39:33]
  input  wire logic [bss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: cmd[1:0]
  input  wire logic [bss_pkg::CMD_W-1:0]        s_axis_tuser,
  // Sample stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata, from bit 0: sample[15:0], silent_run[31:16]
  output logic      [bss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                                  m_axis_tlast
);

  import bss_pkg::*;

  // Derived widths. The ring address of a tap is head + offset + k, which stays below
  // twice the ring depth, so a single conditional subtract wraps it.
  localparam int RAW  = $clog2(RING_DEPTH);
  localparam int KW   = $clog2(TAPS + 1);
  localparam int FMAX = SAMPLES_PER_TICK * OVERSAMPLE;
  localparam int FW   = $clog2(FMAX + 1);
  localparam int OFW  = FW - OS_W + 1;
  localparam int SW   = ((RAW > OFW) ? RAW : OFW) + 1;

  // Request fields.
  cmd_e                       in_cmd;
  logic [POS_W-1:0]           in_pos;
  logic signed [LEVEL_W-1:0]  in_level;
  logic [FRAME_W-1:0]         in_frames;
  logic                       in_accept;

  assign in_cmd    = cmd_e'(s_axis_tuser);
  assign in_pos    = s_axis_tdata[POS_W-1:0];
  assign in_level  = s_axis_tdata[POS_W+LEVEL_W-1:POS_W];
  assign in_frames = s_axis_tdata[POS_W+LEVEL_W+FRAME_W-1:POS_W+LEVEL_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Registers.
  state_e                     state_q, state_d;
  logic [RAW-1:0]             head_q, head_d;
  logic [RAW-1:0]             clr_q, clr_d;
  logic [KW-1:0]              k_q, k_d;
  logic [KW-1:0]              k_end_q, k_end_d;
  logic [RAW-1:0]             wa_q, wa_d;
  logic [ROM_AW-1:0]          ra_q, ra_d;
  logic signed [LEVEL_W-1:0]  level_q, level_d;
  logic signed [LEVEL_W-1:0]  last_level_q, last_level_d;
  logic [FRAME_W-1:0]         frames_q, frames_d;
  logic [SUM_W-1:0]           leaky_q, leaky_d;
  logic [QUIET_W-1:0]         quiet_q, quiet_d;
  logic [FADE_W-1:0]          fade_q;
  logic signed [LEVEL_W-1:0]  neutral_q;
  logic                       s1_vld_q, s1_vld_d;
  logic                       s2_vld_q;
  logic [RAW-1:0]             s1_addr_q;
  logic [RAW-1:0]             s2_addr_q;
  logic [TAP_W-1:0]           rom_q;
  logic signed [2*TAP_W-1:0]  prod_q;
  logic [ENTRY_W-1:0]         hold_q;
  logic [SAMPLE_W-1:0]        smp_q;
  logic [SUM_W-1:0]           mag_q;
  logic                       neg_q;
  logic [SUM_W+FADE_W-1:0]    mul_q;
  logic                       out_vld_q;
  logic [OUT_DATA_W-1:0]      out_data_q;
  logic                       out_last_q;

  // Ring RAM port.
  logic                       ram_we;
  logic [RAW-1:0]             ram_waddr;
  logic [ENTRY_W-1:0]         ram_wdata;
  logic [RAW-1:0]             ram_raddr;
  logic [ENTRY_W-1:0]         ram_rdata;

  bss_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [RAW-1:0] ring_inc(input logic [RAW-1:0] a);
    return (a == RAW'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  // Step set-up. The position, saturated to the end of the tick, is scaled to an
  // oversampled index f. Its low bits give the polyphase phase and its high bits the
  // whole-sample offset. An exact sample hit starts at tap one, since tap zero of that
  // phase is the empty first table entry.
  logic [POS_W-1:0]     pos_sat;
  logic [POS_W+FW-1:0]  f_prod;
  logic [FW-1:0]        f_idx;
  logic [OS_W-1:0]      praw;
  logic [OS_W-1:0]      phase;
  logic [OFW-1:0]       offset;
  logic [KW-1:0]        k_start;
  logic [SW-1:0]        wa_sum;
  logic [SW-1:0]        lim;
  logic [RAW-1:0]       wa_start;
  logic [ROM_AW-1:0]    ra_start;
  logic [KW-1:0]        k_end;

  always_comb begin
    pos_sat  = (in_pos > POS_END) ? POS_END : in_pos;
    f_prod   = (POS_W+FW)'(pos_sat) * (POS_W+FW)'(FMAX);
    f_idx    = f_prod[POS_FRAC+FW-1:POS_FRAC];
    praw     = f_idx[OS_W-1:0];
    phase    = '0 - praw;
    offset   = OFW'(f_idx[FW-1:OS_W]) + OFW'(praw != '0);
    k_start  = (praw == '0) ? KW'(1) : '0;
    ra_start = (praw == '0) ? ROM_AW'(OVERSAMPLE) : ROM_AW'(phase);
    wa_sum   = SW'(head_q) + SW'(offset) + SW'(k_start);
    wa_start = (wa_sum >= SW'(RING_DEPTH)) ? RAW'(wa_sum - SW'(RING_DEPTH)) : RAW'(wa_sum);
    // Taps that would land beyond the end of the ring are dropped.
    lim      = SW'(RING_DEPTH) - SW'(offset);
    k_end    = (lim > SW'(TAPS)) ? KW'(TAPS) : KW'(lim);
  end

  // Render arithmetic. The accumulator is kept as a plain two's-complement vector.
  logic [SUM_W:0]         acc_sum;
  logic [SUM_W-1:0]       acc_sat;
  logic [SUM_W:0]         rnd;
  logic [SUM_W-15:0]      rsh;
  logic [SAMPLE_W-1:0]    smp_d;
  logic [SUM_W-1:0]       fade_m;
  logic [QUIET_W-1:0]     quiet_next;
  logic [ENTRY_W-1:0]     prod_ext;

  always_comb begin
    acc_sum = {leaky_q[SUM_W-1], leaky_q}
            + {{(SUM_W + 1 - ENTRY_W){ram_rdata[ENTRY_W-1]}}, ram_rdata};
    if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
      acc_sat = acc_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[SUM_W-1:0];
    end

    // Round half up: add one half, then an arithmetic shift floors.
    rnd = {leaky_q[SUM_W-1], leaky_q} + (SUM_W+1)'(16384);
    rsh = rnd[SUM_W:15];
    if (!rsh[SUM_W-15] && (|rsh[SUM_W-16:15])) begin
      smp_d = 16'h7FFF;
    end else if (rsh[SUM_W-15] && !(&rsh[SUM_W-16:15])) begin
      smp_d = 16'h8000;
    end else begin
      smp_d = rsh[SAMPLE_W-1:0];
    end

    if (mag_q > SUM_W'(32768)) begin
      quiet_next = '0;
    end else if (quiet_q == {QUIET_W{1'b1}}) begin
      quiet_next = quiet_q;
    end else begin
      quiet_next = quiet_q + 1'b1;
    end

    fade_m   = mul_q[SUM_W+FADE_W-1:FADE_W];
    prod_ext = {{(ENTRY_W - 2*TAP_W){prod_q[2*TAP_W-1]}}, prod_q};
  end

  // Sequencer: next state and RAM port.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    clr_d        = clr_q;
    k_d          = k_q;
    k_end_d      = k_end_q;
    wa_d         = wa_q;
    ra_d         = ra_q;
    level_d      = level_q;
    last_level_d = last_level_q;
    frames_d     = frames_q;
    leaky_d      = leaky_q;
    quiet_d      = quiet_q;
    s1_vld_d     = 1'b0;
    ram_we       = s2_vld_q;
    ram_waddr    = s2_addr_q;
    ram_wdata    = hold_q + prod_ext;
    ram_raddr    = head_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == RAW'(RING_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_cmd)
            CMD_STEP: begin
              // An unchanged level adds nothing to the ring.
              if (in_level != last_level_q) begin
                last_level_d = in_level;
                level_d      = in_level;
                k_d          = k_start;
                k_end_d      = k_end;
                wa_d         = wa_start;
                ra_d         = ra_start;
                if (k_start < k_end) begin
                  state_d = ST_STEP;
                end
              end
            end
            CMD_RENDER: begin
              if (in_frames != '0) begin
                frames_d = (in_frames > FRAME_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES)
                                                               : in_frames;
                state_d  = ST_R_ACC;
              end
            end
            CMD_WAKE: begin
              last_level_d = neutral_q;
            end
            default: begin
            end
          endcase
        end
      end
      ST_STEP: begin
        // One tap a cycle: read ring and table, multiply, then write back. Taps of
        // one step hit distinct entries, so the pipeline needs no forwarding.
        ram_raddr = wa_q;
        s1_vld_d  = 1'b1;
        wa_d      = ring_inc(wa_q);
        ra_d      = ra_q + ROM_AW'(OVERSAMPLE);
        k_d       = k_q + 1'b1;
        if (k_q + 1'b1 == k_end_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Let the last writes land before any later request reads the ring.
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_R_ACC: begin
        leaky_d   = acc_sat;
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = '0;
        head_d    = ring_inc(head_q);
        state_d   = ST_R_MAG;
      end
      ST_R_MAG: begin
        state_d = ST_R_OUT;
      end
      ST_R_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          quiet_d = quiet_next;
          state_d = ST_R_FADE;
        end
      end
      ST_R_FADE: begin
        // The ring read for the next sample is issued here at the advanced head.
        leaky_d  = neg_q ? (~fade_m + 1'b1) : fade_m;
        frames_d = frames_q - 1'b1;
        state_d  = (frames_q == FRAME_W'(1)) ? ST_IDLE : ST_R_ACC;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      head_q       <= '0;
      clr_q        <= '0;
      k_q          <= '0;
      wa_q         <= '0;
      ra_q         <= '0;
      last_level_q <= '0;
      frames_q     <= '0;
      leaky_q      <= '0;
      quiet_q      <= '0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      fade_q       <= 16'd65400;
      neutral_q    <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      clr_q        <= clr_d;
      k_q          <= k_d;
      wa_q         <= wa_d;
      ra_q         <= ra_d;
      last_level_q <= last_level_d;
      frames_q     <= frames_d;
      leaky_q      <= leaky_d;
      quiet_q      <= quiet_d;
      s1_vld_q     <= s1_vld_d;
      s2_vld_q     <= s1_vld_q;
      if (state_q == ST_R_OUT && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FADE_GAIN:     fade_q    <= cfg_wdata_i;
          REG_NEUTRAL_LEVEL: neutral_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    k_end_q   <= k_end_d;
    level_q   <= level_d;
    rom_q     <= IMPULSE_ROM[ra_q];
    s1_addr_q <= wa_q;
    s2_addr_q <= s1_addr_q;
    prod_q    <= (2*TAP_W)'(level_q) * (2*TAP_W)'($signed(rom_q));
    hold_q    <= ram_rdata;
    smp_q     <= smp_d;
    mag_q     <= leaky_q[SUM_W-1] ? (~leaky_q + 1'b1) : leaky_q;
    neg_q     <= leaky_q[SUM_W-1];
    mul_q     <= (SUM_W+FADE_W)'(mag_q) * (SUM_W+FADE_W)'(fade_q);
    if (state_q == ST_R_OUT && (!out_vld_q || m_axis_tready)) begin
      out_data_q <= {quiet_next, smp_q};
      out_last_q <= (frames_q == FRAME_W'(1));
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
